@@ sv/aptr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aptr_pkg
// Shared types and constants for the access point table rank unit.
// ----------------------------------------------------------------------------
package aptr_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam logic [31:0] TTL_RESET = 32'd30000;
    localparam logic [7:0] RSSI_CEILING = 8'sd127;

    localparam logic [1:0] CMD_OBSERVE = 2'd0;
    localparam logic [1:0] CMD_AGE     = 2'd1;
    localparam logic [1:0] CMD_RANK    = 2'd2;

    // one table record as held in the entry RAM
    typedef struct packed {
        logic [47:0] bssid;
        logic [7:0]  rssi;
        logic [7:0]  channel;
        logic [31:0] seen_ms;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] bssid;
        logic [7:0]  rssi;
        logic [7:0]  channel;
        logic [7:0]  ssid_length;
        logic [31:0] now_ms;
        logic [3:0]  rank;
    } item_t;

    typedef struct packed {
        logic        stored;
        logic [3:0]  slot_used;
        logic [4:0]  entry_count;
        logic [31:0] change_count;
        logic        found;
        rec_t        hit;
    } result_t;

endpackage

@@ sv/ap_table_rssi_evict_rank_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap_table_rssi_evict_rank_unit
// Access point table: observe / age / rank over a RAM-held entry table.
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// s_ (item) | s_valid / s_ready    | cmd, bssid, rssi, channel, ssid_length,
//           |                      | now_ms, rank
// m_ (res)  | m_valid / m_ready    | stored, slot_used, entry_count,
//           |                      | change_count, found, hit_*
// cfg       | cfg_valid / cfg_ready| cfg_data -> ttl_ms
//
// Sequence from accept to next accept (N = entries): observe issues N reads
// into the registered RAM read, checks each entry as its data returns, then
// passes through the decide/write, done and idle states; age has no decide.
// Rank runs up to rank+1 passes over the N entries, each finding the next
// entry in descending RSSI order and ending in the decide state.
// Empty-SSID observe and unused commands go straight from idle to done.
// Reset: synchronous active low; clears valid bits, entry count, generation
// count and ttl_ms to 30000. Entry RAM contents are not cleared.
// Stalls: the result sits in an output register; the next item is taken while
// it waits. A second result waits in the sequencer until m_ready frees it.
// ----------------------------------------------------------------------------
module ap_table_rssi_evict_rank_unit #(
    parameter int TABLE_ENTRIES = aptr_pkg::DEF_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [47:0] s_bssid,
    input  logic signed [7:0] s_rssi,
    input  logic [7:0]  s_channel,
    input  logic [7:0]  s_ssid_length,
    input  logic [31:0] s_now_ms,
    input  logic [3:0]  s_rank,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_stored,
    output logic [3:0]  m_slot_used,
    output logic [4:0]  m_entry_count,
    output logic [31:0] m_change_count,
    output logic        m_found,
    output logic [47:0] m_hit_bssid,
    output logic signed [7:0] m_hit_rssi,
    output logic [7:0]  m_hit_channel,
    output logic [31:0] m_hit_seen_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    aptr_pkg::item_t   item;
    aptr_pkg::result_t res;
    aptr_pkg::result_t out_reg, out_next;
    logic              out_v_reg, out_v_next;
    logic [31:0]       ttl_reg, ttl_next;
    logic              res_valid;
    logic              res_ready;

    assign item = '{cmd: s_cmd, bssid: s_bssid, rssi: s_rssi, channel: s_channel,
                    ssid_length: s_ssid_length, now_ms: s_now_ms, rank: s_rank};

    aptr_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (item),
        .ttl       (ttl_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: refills in the same cycle it drains
    assign res_ready = !out_v_reg || m_ready;

    always_comb begin
        out_next   = out_reg;
        out_v_next = out_v_reg;
        if (m_ready) begin
            out_v_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_next   = res;
            out_v_next = 1'b1;
        end
        ttl_next = cfg_valid ? cfg_data : ttl_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            ttl_reg   <= aptr_pkg::TTL_RESET;
        end else begin
            out_v_reg <= out_v_next;
            ttl_reg   <= ttl_next;
        end
        out_reg <= out_next;
    end

    assign cfg_ready      = 1'b1;
    assign m_valid        = out_v_reg;
    assign m_stored       = out_reg.stored;
    assign m_slot_used    = out_reg.slot_used;
    assign m_entry_count  = out_reg.entry_count;
    assign m_change_count = out_reg.change_count;
    assign m_found        = out_reg.found;
    assign m_hit_bssid    = out_reg.hit.bssid;
    assign m_hit_rssi     = out_reg.hit.rssi;
    assign m_hit_channel  = out_reg.hit.channel;
    assign m_hit_seen_ms  = out_reg.hit.seen_ms;

    // a stored observe leaves at least one valid entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stored |-> m_entry_count != 5'd0)
        else $error("stored result with empty table");

    // a rank hit comes with a non-empty table and never with a store
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_entry_count != 5'd0 && !m_stored)
        else $error("rank hit inconsistent with count or stored");

    // the sequencer never offers a result while taking a new item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && res_valid))
        else $error("sequencer idle and done at once");

endmodule

@@ sv/aptr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aptr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aptr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/aptr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aptr_ctrl
// Sequencer: walks the entry RAM one slot per cycle for observe, age and rank.
// ----------------------------------------------------------------------------
module aptr_ctrl #(
    parameter int TABLE_ENTRIES = aptr_pkg::DEF_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aptr_pkg::item_t   in_item,
    input  logic [31:0]       ttl,
    output logic              res_valid,
    input  logic              res_ready,
    output aptr_pkg::result_t res
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW:0] LAST_ISSUE = (IW + 1)'(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]              state_reg, state_next;
    aptr_pkg::item_t         item_reg, item_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [31:0]             gen_reg, gen_next;
    logic [IW:0]             rd_idx_reg, rd_idx_next;
    logic                    pv_reg, pv_next;
    logic [IW-1:0]           pidx_reg, pidx_next;
    // observe trackers
    logic                    match_f_reg, match_f_next;
    logic [IW-1:0]           match_s_reg, match_s_next;
    logic                    free_f_reg, free_f_next;
    logic [IW-1:0]           free_s_reg, free_s_next;
    logic                    weak_f_reg, weak_f_next;
    logic [IW-1:0]           weak_s_reg, weak_s_next;
    logic [7:0]              weak_r_reg, weak_r_next;
    // rank trackers
    logic                    prev_f_reg, prev_f_next;
    logic [7:0]              prev_r_reg, prev_r_next;
    logic [IW-1:0]           prev_s_reg, prev_s_next;
    logic                    best_f_reg, best_f_next;
    logic [7:0]              best_r_reg, best_r_next;
    logic [IW-1:0]           best_s_reg, best_s_next;
    aptr_pkg::rec_t          best_rec_reg, best_rec_next;
    logic [3:0]              pass_reg, pass_next;
    // result
    logic                    stored_reg, stored_next;
    logic [3:0]              slot_reg, slot_next;
    logic                    found_reg, found_next;
    aptr_pkg::rec_t          hit_reg, hit_next;

    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [aptr_pkg::REC_W-1:0] ram_rdata;
    aptr_pkg::rec_t          rec;
    logic                    v;
    logic [IW-1:0]           wslot;
    logic                    wgo;

    aptr_ram #(
        .WIDTH (aptr_pkg::REC_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({item_reg.bssid, item_reg.rssi, item_reg.channel, item_reg.now_ms}),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign rec = aptr_pkg::rec_t'(ram_rdata);
    assign v   = valid_reg[pidx_reg];

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        gen_next      = gen_reg;
        rd_idx_next   = rd_idx_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        match_f_next  = match_f_reg;
        match_s_next  = match_s_reg;
        free_f_next   = free_f_reg;
        free_s_next   = free_s_reg;
        weak_f_next   = weak_f_reg;
        weak_s_next   = weak_s_reg;
        weak_r_next   = weak_r_reg;
        prev_f_next   = prev_f_reg;
        prev_r_next   = prev_r_reg;
        prev_s_next   = prev_s_reg;
        best_f_next   = best_f_reg;
        best_r_next   = best_r_reg;
        best_s_next   = best_s_reg;
        best_rec_next = best_rec_reg;
        pass_next     = pass_reg;
        stored_next   = stored_reg;
        slot_next     = slot_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        wslot         = '0;
        wgo           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next    = in_item;
                    rd_idx_next  = '0;
                    match_f_next = 1'b0;
                    free_f_next  = 1'b0;
                    weak_f_next  = 1'b0;
                    weak_r_next  = aptr_pkg::RSSI_CEILING;
                    prev_f_next  = 1'b0;
                    best_f_next  = 1'b0;
                    pass_next    = '0;
                    stored_next  = 1'b0;
                    slot_next    = '0;
                    found_next   = 1'b0;
                    hit_next     = '0;
                    if ((in_item.cmd == aptr_pkg::CMD_OBSERVE && in_item.ssid_length != 8'd0)
                        || in_item.cmd == aptr_pkg::CMD_AGE
                        || in_item.cmd == aptr_pkg::CMD_RANK) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // read issue side
                if (rd_idx_reg != LAST_ISSUE) begin
                    pv_next     = 1'b1;
                    pidx_next   = rd_idx_reg[IW-1:0];
                    rd_idx_next = rd_idx_reg + (IW + 1)'(1);
                end
                // data side, in the cycle after each read is issued
                if (pv_reg) begin
                    case (item_reg.cmd)
                        aptr_pkg::CMD_OBSERVE: begin
                            if (v && rec.bssid == item_reg.bssid && !match_f_reg) begin
                                match_f_next = 1'b1;
                                match_s_next = pidx_reg;
                            end
                            if (!v && !free_f_reg) begin
                                free_f_next = 1'b1;
                                free_s_next = pidx_reg;
                            end
                            if (v && $signed(rec.rssi) < $signed(weak_r_reg)) begin
                                weak_f_next = 1'b1;
                                weak_s_next = pidx_reg;
                                weak_r_next = rec.rssi;
                            end
                        end
                        aptr_pkg::CMD_AGE: begin
                            if (v && (item_reg.now_ms - rec.seen_ms) > ttl) begin
                                valid_next[pidx_reg] = 1'b0;
                                cnt_next = cnt_reg - CW'(1);
                                gen_next = gen_reg + 32'd1;
                            end
                        end
                        default: begin
                            // rank: next entry after prev in (rssi desc, slot asc) order
                            if (v && (!prev_f_reg
                                      || $signed(rec.rssi) < $signed(prev_r_reg)
                                      || (rec.rssi == prev_r_reg && pidx_reg > prev_s_reg))
                                  && (!best_f_reg
                                      || $signed(rec.rssi) > $signed(best_r_reg))) begin
                                best_f_next   = 1'b1;
                                best_r_next   = rec.rssi;
                                best_s_next   = pidx_reg;
                                best_rec_next = rec;
                            end
                        end
                    endcase
                    if (pidx_reg == LAST_SLOT) begin
                        state_next = (item_reg.cmd == aptr_pkg::CMD_AGE) ? ST_DONE : ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (item_reg.cmd == aptr_pkg::CMD_OBSERVE) begin
                    if (match_f_reg) begin
                        wslot = match_s_reg;
                        wgo   = 1'b1;
                    end else if (free_f_reg) begin
                        wslot = free_s_reg;
                        wgo   = 1'b1;
                    end else if (weak_f_reg && $signed(item_reg.rssi) > $signed(weak_r_reg)) begin
                        wslot = weak_s_reg;
                        wgo   = 1'b1;
                    end
                    if (wgo) begin
                        ram_we            = 1'b1;
                        ram_waddr         = wslot;
                        valid_next[wslot] = 1'b1;
                        if (!valid_reg[wslot]) begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                        gen_next    = gen_reg + 32'd1;
                        stored_next = 1'b1;
                        slot_next   = 4'(wslot);
                    end
                    state_next = ST_DONE;
                end else begin
                    if (!best_f_reg) begin
                        state_next = ST_DONE;
                    end else if (pass_reg == item_reg.rank) begin
                        found_next = 1'b1;
                        hit_next   = best_rec_reg;
                        state_next = ST_DONE;
                    end else begin
                        prev_f_next = 1'b1;
                        prev_r_next = best_r_reg;
                        prev_s_next = best_s_reg;
                        best_f_next = 1'b0;
                        pass_next   = pass_reg + 4'd1;
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            gen_reg   <= '0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            gen_reg   <= gen_next;
            pv_reg    <= pv_next;
        end
        item_reg     <= item_next;
        rd_idx_reg   <= rd_idx_next;
        pidx_reg     <= pidx_next;
        match_f_reg  <= match_f_next;
        match_s_reg  <= match_s_next;
        free_f_reg   <= free_f_next;
        free_s_reg   <= free_s_next;
        weak_f_reg   <= weak_f_next;
        weak_s_reg   <= weak_s_next;
        weak_r_reg   <= weak_r_next;
        prev_f_reg   <= prev_f_next;
        prev_r_reg   <= prev_r_next;
        prev_s_reg   <= prev_s_next;
        best_f_reg   <= best_f_next;
        best_r_reg   <= best_r_next;
        best_s_reg   <= best_s_next;
        best_rec_reg <= best_rec_next;
        pass_reg     <= pass_next;
        stored_reg   <= stored_next;
        slot_reg     <= slot_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res              = '0;
        res.stored       = stored_reg;
        res.slot_used    = slot_reg;
        res.entry_count  = (cnt_reg > CW'(31)) ? 5'd31 : 5'(cnt_reg);
        res.change_count = gen_reg;
        res.found        = found_reg;
        res.hit          = hit_reg;
    end

endmodule

@@ tb/sv/tb_ap_table_rssi_evict_rank_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ap_table_rssi_evict_rank_unit
// Self-checking bench for the access point table: a directed table of
// observe / age / rank / unused items, then random traffic, every result compared
// against a behavioral table model kept in the bench.
// ----------------------------------------------------------------------------
module tb_ap_table_rssi_evict_rank_unit;

    localparam int N = aptr_pkg::DEF_ENTRIES;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [47:0] s_bssid;
    logic signed [7:0] s_rssi;
    logic [7:0]  s_channel;
    logic [7:0]  s_ssid_length;
    logic [31:0] s_now_ms;
    logic [3:0]  s_rank;
    logic        m_valid;
    logic        m_ready;
    logic        m_stored;
    logic [3:0]  m_slot_used;
    logic [4:0]  m_entry_count;
    logic [31:0] m_change_count;
    logic        m_found;
    logic [47:0] m_hit_bssid;
    logic signed [7:0] m_hit_rssi;
    logic [7:0]  m_hit_channel;
    logic [31:0] m_hit_seen_ms;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    ap_table_rssi_evict_rank_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_bssid(s_bssid),
        .s_rssi(s_rssi), .s_channel(s_channel), .s_ssid_length(s_ssid_length),
        .s_now_ms(s_now_ms), .s_rank(s_rank),
        .m_valid(m_valid), .m_ready(m_ready), .m_stored(m_stored),
        .m_slot_used(m_slot_used), .m_entry_count(m_entry_count),
        .m_change_count(m_change_count), .m_found(m_found),
        .m_hit_bssid(m_hit_bssid), .m_hit_rssi(m_hit_rssi),
        .m_hit_channel(m_hit_channel), .m_hit_seen_ms(m_hit_seen_ms),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // bench copy of the table
    logic        tbl_valid [N];
    logic [47:0] tbl_bssid [N];
    logic signed [7:0] tbl_rssi [N];
    logic [7:0]  tbl_chan  [N];
    logic [31:0] tbl_seen  [N];
    logic [31:0] gen_count;
    logic [31:0] ttl;

    aptr_pkg::result_t pending_results[$];
    int          errors = 0;
    longint      cycles = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_stored = 0;
    int          n_found = 0;
    int          n_expired = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // directed stimulus: item plus, where obvious, the full expected result
    typedef struct {
        aptr_pkg::item_t   it;
        logic              known;
        aptr_pkg::result_t res;
    } row_t;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [4:0] live_count();
        logic [4:0] c;
        c = 0;
        for (int i = 0; i < N; i++) if (tbl_valid[i]) c++;
        return c;
    endfunction

    // apply one item to the bench table, return what the block should report
    function automatic aptr_pkg::result_t table_step(aptr_pkg::item_t it);
        aptr_pkg::result_t r;
        int slot;
        int weakest;
        logic signed [7:0] weak_rssi;
        logic signed [7:0] nr;
        int pos;
        r = '0;
        nr = it.rssi;
        if (it.cmd == aptr_pkg::CMD_OBSERVE && it.ssid_length != 0) begin
            slot = -1;
            weakest = -1;
            weak_rssi = 8'sd127;
            for (int i = 0; i < N; i++) begin
                if (tbl_valid[i] && tbl_bssid[i] == it.bssid) begin
                    slot = i;
                    break;
                end
                if (!tbl_valid[i] && slot < 0) slot = i;
                if (tbl_valid[i] && tbl_rssi[i] < weak_rssi) begin
                    weak_rssi = tbl_rssi[i];
                    weakest = i;
                end
            end
            if (slot < 0 && weakest >= 0 && nr > weak_rssi) slot = weakest;
            if (slot >= 0) begin
                tbl_valid[slot] = 1'b1;
                tbl_bssid[slot] = it.bssid;
                tbl_rssi[slot]  = nr;
                tbl_chan[slot]  = it.channel;
                tbl_seen[slot]  = it.now_ms;
                gen_count++;
                r.stored = 1'b1;
                r.slot_used = slot[3:0];
            end
        end else if (it.cmd == aptr_pkg::CMD_AGE) begin
            for (int i = 0; i < N; i++) begin
                if (tbl_valid[i] && (it.now_ms - tbl_seen[i]) > ttl) begin
                    tbl_valid[i] = 1'b0;
                    gen_count++;
                    n_expired++;
                end
            end
        end else if (it.cmd == aptr_pkg::CMD_RANK) begin
            for (int i = 0; i < N; i++) begin
                if (!tbl_valid[i]) continue;
                pos = 0;
                for (int j = 0; j < N; j++) begin
                    if (!tbl_valid[j]) continue;
                    if (tbl_rssi[j] > tbl_rssi[i] || (j < i && tbl_rssi[j] == tbl_rssi[i]))
                        pos++;
                end
                if (pos == it.rank) begin
                    r.found = 1'b1;
                    r.hit.bssid = tbl_bssid[i];
                    r.hit.rssi = tbl_rssi[i];
                    r.hit.channel = tbl_chan[i];
                    r.hit.seen_ms = tbl_seen[i];
                    break;
                end
            end
        end
        r.entry_count = live_count();
        r.change_count = gen_count;
        return r;
    endfunction

    // result side: random back-pressure, compare each transfer
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        aptr_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_stored !== want.stored || m_slot_used !== want.slot_used ||
                    m_entry_count !== want.entry_count ||
                    m_change_count !== want.change_count || m_found !== want.found ||
                    m_hit_bssid !== want.hit.bssid || m_hit_rssi !== want.hit.rssi ||
                    m_hit_channel !== want.hit.channel ||
                    m_hit_seen_ms !== want.hit.seen_ms) begin
                    $display("%0t: mismatch exp st=%0d sl=%0d cnt=%0d gen=%0d f=%0d %h %0d %0d %h",
                             $time, want.stored, want.slot_used, want.entry_count,
                             want.change_count, want.found, want.hit.bssid,
                             $signed(want.hit.rssi), want.hit.channel, want.hit.seen_ms);
                    $display("%0t:          got st=%0d sl=%0d cnt=%0d gen=%0d f=%0d %h %0d %0d %h",
                             $time, m_stored, m_slot_used, m_entry_count, m_change_count,
                             m_found, m_hit_bssid, m_hit_rssi, m_hit_channel, m_hit_seen_ms);
                    errors++;
                end
            end
        end
    end

    // one item transfer; prediction is made at acceptance. Valid stays high
    // into the next item unless the sender idles; callers drop it when done.
    task automatic send_item(aptr_pkg::item_t it, logic known, aptr_pkg::result_t res);
        aptr_pkg::result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_bssid <= it.bssid;
        s_rssi <= it.rssi;
        s_channel <= it.channel;
        s_ssid_length <= it.ssid_length;
        s_now_ms <= it.now_ms;
        s_rank <= it.rank;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = table_step(it);
        if (pred.stored) n_stored++;
        if (pred.found) n_found++;
        if (known && pred !== res) begin
            $display("%0t: table row %0d disagrees with bench model", $time, n_items);
            errors++;
        end
        pending_results.push_back(pred);
        n_items++;
        @(negedge aclk);
    endtask

    // ttl write, only with the block drained
    task automatic write_ttl(logic [31:0] v);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20 * (N + 2)) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ttl = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic aptr_pkg::item_t mk(logic [1:0] c, logic [47:0] b, logic [7:0] r,
                                           logic [7:0] ch, logic [7:0] sl, logic [31:0] now,
                                           logic [3:0] rk);
        aptr_pkg::item_t it;
        it.cmd = c; it.bssid = b; it.rssi = r; it.channel = ch;
        it.ssid_length = sl; it.now_ms = now; it.rank = rk;
        return it;
    endfunction

    // small BSSID pool so updates and evictions are frequent
    function automatic aptr_pkg::item_t rand_item();
        aptr_pkg::item_t it;
        int sel;
        it.cmd = $urandom_range(99) < 55 ? aptr_pkg::CMD_OBSERVE :
                 ($urandom_range(99) < 30 ? aptr_pkg::CMD_AGE : aptr_pkg::CMD_RANK);
        if ($urandom_range(99) < 3) it.cmd = CMD_UNUSED;
        sel = $urandom_range(99);
        it.bssid = sel < 70 ? 48'(64'h0000_a0b0_c000 + $urandom_range(23)) :
                   48'({$urandom, $urandom});
        it.rssi = $urandom_range(99) < 10 ? 8'sd127 : 8'($urandom);
        it.channel = 8'($urandom);
        it.ssid_length = $urandom_range(99) < 8 ? 8'd0 : 8'($urandom_range(255, 1));
        it.now_ms = $urandom_range(99) < 80 ? 32'($urandom_range(60000)) : $urandom;
        it.rank = 4'($urandom);
        return it;
    endfunction

    initial begin
        row_t rows[$];
        row_t rw;
        aptr_pkg::result_t z;
        aptr_pkg::result_t r;
        logic [31:0] ttl_set [4];
        int per_phase;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = '0; s_bssid = '0; s_rssi = '0; s_channel = '0;
        s_ssid_length = '0; s_now_ms = '0; s_rank = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < N; i++) begin
            tbl_valid[i] = 1'b0; tbl_bssid[i] = '0; tbl_rssi[i] = '0;
            tbl_chan[i] = '0; tbl_seen[i] = '0;
        end
        gen_count = '0;
        ttl = aptr_pkg::TTL_RESET;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        z = '0;
        rw.known = 1'b1; rw.res = z;
        rw.it = mk(aptr_pkg::CMD_RANK, 0, 0, 0, 0, 0, 0);   rows.push_back(rw); // empty rank
        rw.it = mk(CMD_UNUSED, 1, 5, 5, 5, 5, 5);          rows.push_back(rw); // unused cmd
        rw.it = mk(aptr_pkg::CMD_OBSERVE, 48'h1, 8'sd10, 1, 0, 0, 0);
        rows.push_back(rw); // empty SSID
        r = z; r.stored = 1; r.entry_count = 1; r.change_count = 1;
        rw.it = mk(aptr_pkg::CMD_OBSERVE, 48'hffff_ffff_ffff, 8'sd127, 8'hff, 8'hff,
                   32'hffff_ffff, 0);
        rw.res = r; rows.push_back(rw);
        r = z; r.entry_count = 1; r.change_count = 1; r.found = 1;
        r.hit = '{48'hffff_ffff_ffff, 8'h7f, 8'hff, 32'hffff_ffff};
        rw.it = mk(aptr_pkg::CMD_RANK, 0, 0, 0, 0, 0, 0); rw.res = r; rows.push_back(rw);
        r = z; r.stored = 1; r.slot_used = 1; r.entry_count = 2; r.change_count = 2;
        rw.it = mk(aptr_pkg::CMD_OBSERVE, 48'h0, 8'h80, 8'h00, 8'd1, 32'd0, 0);
        rw.res = r; rows.push_back(rw);
        rw.known = 1'b0;
        rw.it = mk(aptr_pkg::CMD_RANK, 0, 0, 0, 0, 0, 1);  rows.push_back(rw);
        rw.it = mk(aptr_pkg::CMD_RANK, 0, 0, 0, 0, 0, 15); rows.push_back(rw);
        // fill the table, then evictions with ties
        for (int i = 0; i < 15; i++) begin
            rw.it = mk(aptr_pkg::CMD_OBSERVE, 48'h100 + i, 8'(i % 4 - 20), 8'(i), 8'd4,
                       32'd100, 0);
            rows.push_back(rw);
        end
        rw.it = mk(aptr_pkg::CMD_OBSERVE, 48'h200, 8'h80, 3, 4, 200, 0); rows.push_back(rw);
        rw.it = mk(aptr_pkg::CMD_OBSERVE, 48'h201, 8'sd5, 3, 4, 200, 0); rows.push_back(rw);
        rw.it = mk(aptr_pkg::CMD_AGE, 0, 0, 0, 0, 32'd30100, 0);         rows.push_back(rw);
        rw.it = mk(aptr_pkg::CMD_AGE, 0, 0, 0, 0, 32'd30101, 0);         rows.push_back(rw);
        foreach (rows[k]) send_item(rows[k].it, rows[k].known, rows[k].res);

        ttl_set = '{32'd0, 32'hffff_ffff, 32'd500, 32'd20000};
        per_phase = 1350 / 12;
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 4 == 0 || ph % 4 == 2) write_ttl(ttl_set[(ph / 2) % 4]);
            case (ph / 4)
                0: begin send_idle_pct = 28; recv_idle_pct = 66; end
                1: begin send_idle_pct = 66; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < per_phase; k++) send_item(rand_item(), 1'b0, z);
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20 * (N + 2)) @(negedge aclk);
        $display("ran %0d items, %0d results, %0d stores, %0d rank hits, %0d expiries",
                 n_items, n_results, n_stored, n_found, n_expired);
        $display("ttl settings covered 0, max, 500, 20000 and the reset value");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
